// ===== hw/rtl/ipi_pkg.sv =====
`default_nettype none

package ipi_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int LUT_ONE    = 256;
  localparam int LUT_ZERO   = 512;
  localparam int LUT_SIZE   = 1025;

  localparam int LAW  = $clog2(LUT_SIZE);
  localparam int IW   = LAW + 3;
  localparam int CW   = 11;
  localparam int TW   = 12;
  localparam int KW   = 16;
  localparam int WXYW = 2 * KW;
  localparam int PW   = WXYW + 17;
  localparam int ACCW = PW + 5;

  localparam longint KD3  = longint'(LUT_ONE) * LUT_ONE * LUT_ONE;
  localparam longint KDEN = 2 * KD3;

  localparam logic [1:0] KIND_BICUBIC  = 2'd0;
  localparam logic [1:0] KIND_BILINEAR = 2'd1;
  localparam logic [1:0] KIND_NEAREST  = 2'd2;
  localparam logic [1:0] KIND_ZERO     = 2'd3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KIND   = 2'd2;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef logic signed [KW-1:0] krom_t [LUT_SIZE];

  typedef struct packed {
    logic                 clear;
    logic                 valid;
    logic signed [KW-1:0] wx;
    logic signed [KW-1:0] wy;
    logic [15:0]          pixel;
  } mac_in_t;

  function automatic krom_t kernel_table();
    krom_t  t;
    longint n;
    longint num;
    longint a;
    longint q;
    for (int i = 0; i < LUT_SIZE; i++) begin
      n = longint'(i) - LUT_ZERO;
      if (n < 0) begin
        n = -n;
      end
      if (n > 2 * LUT_ONE) begin
        num = 0;
      end else if (n <= LUT_ONE) begin
        num = 3 * n * n * n - 5 * n * n * LUT_ONE + 2 * KD3;
      end else begin
        num = -n * n * n + 5 * n * n * LUT_ONE - 8 * n * LUT_ONE * LUT_ONE + 4 * KD3;
      end
      a = num * 16384 + KD3;
      q = a / KDEN;
      if ((a % KDEN) != 0 && a < 0) begin
        q = q - 1;
      end
      t[i] = KW'(q);
    end
    return t;
  endfunction

  // Division by 256 with the quotient truncated toward zero.
  function automatic logic signed [CW-1:0] tdiv256(input logic signed [18:0] v);
    logic [18:0]   mag;
    logic [CW-1:0] q;
    mag = v[18] ? 19'(-v) : 19'(v);
    q   = CW'(mag >> 8);
    return v[18] ? -$signed(q) : $signed(q);
  endfunction

  // Table step of a signed fraction, rounded half up toward zero.
  function automatic logic signed [IW-1:0] table_step(input logic signed [8:0] f);
    logic signed [31:0] num;
    logic [31:0]        mag;
    logic [IW-1:0]      q;
    num = 32'(f) * (2 * LUT_ONE) + 32'sd256;
    mag = num[31] ? 32'(-num) : 32'(num);
    q   = IW'(mag >> 9);
    return num[31] ? -$signed(q) : $signed(q);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/image_pixel_interpolator.sv =====
// Image pixel interpolator: a load word is written and leaves the block ready again.
// A sample passes setup, tap issue, drain and done states to its result; kind three skips
// the taps. The taps go one per cycle through a shared MAC pipeline.
// One sample is in work at a time; the next word can be taken once the result is shown.
// Synchronous reset clears control and sets width and height to 256 and kind to bicubic;
// the image store holds no defined data until written.
`default_nettype none

module image_pixel_interpolator #(
  parameter int MAX_WIDTH  = ipi_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = ipi_pkg::MAX_HEIGHT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic               mode,
  input  wire logic [15:0]        load_address,
  input  wire logic [15:0]        load_value,
  input  wire logic signed [17:0] coord_x,
  input  wire logic signed [17:0] coord_y,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [15:0]             sample_value,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [8:0]         cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = ipi_pkg::CW;
  localparam int TW    = ipi_pkg::TW;
  localparam int IW    = ipi_pkg::IW;
  localparam int KW    = ipi_pkg::KW;
  localparam int LAW   = ipi_pkg::LAW;
  localparam int ACCW  = ipi_pkg::ACCW;

  typedef enum logic [2:0] {S_IDLE, S_SETUP, S_ISSUE, S_DRAIN, S_DONE} state_t;

  state_t state;

  logic [8:0] image_width;
  logic [8:0] image_height;
  logic [1:0] interp_kind;

  logic signed [17:0]   cx;
  logic signed [17:0]   cy;
  logic [1:0]           kind_q;
  logic signed [CW-1:0] x1;
  logic signed [CW-1:0] y1;
  logic signed [CW-1:0] xn;
  logic signed [CW-1:0] yn;
  logic signed [8:0]    fx;
  logic signed [8:0]    fy;
  logic signed [IW-1:0] dx;
  logic signed [IW-1:0] dy;
  logic [4:0]           ntaps;
  logic [3:0]           cnt;

  logic                 s1_valid;
  logic                 s1_zero;
  logic                 s1_bic;
  logic signed [KW-1:0] s1_wx;
  logic signed [KW-1:0] s1_wy;

  logic                  accept;
  logic                  store_we;
  logic [WW-1:0]         w_eff;
  logic [HW-1:0]         h_eff;
  logic signed [CW-1:0]  x1_c;
  logic signed [CW-1:0]  y1_c;
  logic signed [TW-1:0]  tx;
  logic signed [TW-1:0]  ty;
  logic signed [IW-1:0]  xl;
  logic signed [IW-1:0]  yl;
  logic signed [KW-1:0]  wx_c;
  logic signed [KW-1:0]  wy_c;
  logic                  tap_zero;
  logic [AW-1:0]         raddr;
  logic [15:0]           rdata;
  logic signed [KW-1:0]  kx;
  logic signed [KW-1:0]  ky;
  ipi_pkg::mac_in_t      tap;
  logic signed [ACCW-1:0] acc;
  logic                  mac_busy;
  logic signed [ACCW-1:0] rnd;
  logic [15:0]           result_c;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign store_we   = accept && (mode == ipi_pkg::MODE_LOAD)
                      && (32'(load_address) < 32'(DEPTH));

  assign w_eff = (32'(image_width) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(image_width);
  assign h_eff = (32'(image_height) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(image_height);

  assign x1_c = ipi_pkg::tdiv256(19'(cx));
  assign y1_c = ipi_pkg::tdiv256(19'(cy));

  always_comb begin
    tx   = TW'(xn);
    ty   = TW'(yn);
    wx_c = KW'(256);
    wy_c = KW'(256);
    xl   = IW'(ipi_pkg::LUT_ZERO - ipi_pkg::LUT_ONE) + IW'(cnt[1:0]) * IW'(ipi_pkg::LUT_ONE)
           - dx;
    yl   = IW'(ipi_pkg::LUT_ZERO - ipi_pkg::LUT_ONE) + IW'(cnt[3:2]) * IW'(ipi_pkg::LUT_ONE)
           - dy;
    unique case (kind_q)
      ipi_pkg::KIND_BICUBIC: begin
        tx = TW'(x1) + TW'(cnt[1:0]) - TW'(1);
        ty = TW'(y1) + TW'(cnt[3:2]) - TW'(1);
      end
      ipi_pkg::KIND_BILINEAR: begin
        tx   = TW'(x1) + TW'(cnt[0]);
        ty   = TW'(y1) + TW'(cnt[1]);
        wx_c = cnt[0] ? KW'(fx) : KW'(256) - KW'(fx);
        wy_c = cnt[1] ? KW'(fy) : KW'(256) - KW'(fy);
      end
      default: begin
      end
    endcase
    tap_zero = tx[TW-1] || ty[TW-1] || !(32'(tx) < 32'(w_eff)) || !(32'(ty) < 32'(h_eff));
    if (kind_q == ipi_pkg::KIND_BICUBIC) begin
      if (xl[IW-1] || (xl >= $signed(IW'(ipi_pkg::LUT_SIZE))) ||
          yl[IW-1] || (yl >= $signed(IW'(ipi_pkg::LUT_SIZE)))) begin
        tap_zero = 1'b1;
      end
    end
    raddr = AW'(ty) * AW'(w_eff) + AW'(tx);
  end

  ipi_store #(.AW(AW)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (AW'(load_address)),
    .wdata (load_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  ipi_krom u_krom (
    .clk    (clk),
    .addr_x (LAW'(xl)),
    .addr_y (LAW'(yl)),
    .data_x (kx),
    .data_y (ky)
  );

  always_comb begin
    tap.clear = (state == S_SETUP);
    tap.valid = s1_valid;
    tap.wx    = s1_zero ? '0 : (s1_bic ? kx : s1_wx);
    tap.wy    = s1_zero ? '0 : (s1_bic ? ky : s1_wy);
    tap.pixel = s1_zero ? 16'd0 : rdata;
  end

  ipi_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .tap  (tap),
    .acc  (acc),
    .busy (mac_busy)
  );

  always_comb begin
    if (kind_q == ipi_pkg::KIND_BICUBIC) begin
      rnd = (acc + (ACCW'(1) <<< 27)) >>> 28;
    end else begin
      rnd = (acc + (ACCW'(1) <<< 15)) >>> 16;
    end
    if (acc[ACCW-1]) begin
      result_c = 16'd0;
    end else if (rnd > $signed(ACCW'(65535))) begin
      result_c = 16'hFFFF;
    end else begin
      result_c = rnd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      s1_valid     <= 1'b0;
      image_width  <= 9'd256;
      image_height <= 9'd256;
      interp_kind  <= ipi_pkg::KIND_BICUBIC;
      cnt          <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          ipi_pkg::REG_WIDTH:  image_width  <= cfg_data;
          ipi_pkg::REG_HEIGHT: image_height <= cfg_data;
          ipi_pkg::REG_KIND:   interp_kind  <= cfg_data[1:0];
          default: begin
          end
        endcase
      end
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      s1_valid <= (state == S_ISSUE);
      unique case (state)
        S_IDLE: begin
          if (accept && mode == ipi_pkg::MODE_SAMPLE) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          cnt <= '0;
          unique case (kind_q)
            ipi_pkg::KIND_BICUBIC:  ntaps <= 5'd16;
            ipi_pkg::KIND_BILINEAR: ntaps <= 5'd4;
            ipi_pkg::KIND_NEAREST:  ntaps <= 5'd1;
            default:                ntaps <= 5'd0;
          endcase
          state <= (kind_q == ipi_pkg::KIND_ZERO) ? S_DRAIN : S_ISSUE;
        end
        S_ISSUE: begin
          cnt <= cnt + 4'd1;
          if ({1'b0, cnt} + 5'd1 == ntaps) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!s1_valid && !mac_busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            sample_value <= result_c;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    if (accept) begin
      cx     <= coord_x;
      cy     <= coord_y;
      kind_q <= interp_kind;
    end
    if (state == S_SETUP) begin
      x1 <= x1_c;
      y1 <= y1_c;
      fx <= 9'(19'(cx) - (19'(x1_c) <<< 8));
      fy <= 9'(19'(cy) - (19'(y1_c) <<< 8));
      dx <= ipi_pkg::table_step(9'(19'(cx) - (19'(x1_c) <<< 8)));
      dy <= ipi_pkg::table_step(9'(19'(cy) - (19'(y1_c) <<< 8)));
      xn <= ipi_pkg::tdiv256(19'(cx) + 19'sd128);
      yn <= ipi_pkg::tdiv256(19'(cy) + 19'sd128);
    end
    s1_zero <= tap_zero;
    s1_bic  <= (kind_q == ipi_pkg::KIND_BICUBIC);
    s1_wx   <= wx_c;
    s1_wy   <= wy_c;
  end

`ifndef NO_ASSERTIONS
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!s1_valid && !mac_busy))
    else $error("tap pipeline active while idle");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE) |-> ({1'b0, cnt} < ntaps))
    else $error("tap counter beyond tap count");

  a_zero_kind: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && kind_q == ipi_pkg::KIND_ZERO) |-> (acc == '0))
    else $error("accumulator not clear for kind three");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ipi_store.sv =====
`default_nettype none

module ipi_store #(
  parameter int AW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [15:0]   rdata
);

  logic [15:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ipi_krom.sv =====
`default_nettype none

module ipi_krom (
  input  wire logic                          clk,
  input  wire logic [ipi_pkg::LAW-1:0]       addr_x,
  input  wire logic [ipi_pkg::LAW-1:0]       addr_y,
  output logic signed [ipi_pkg::KW-1:0]      data_x,
  output logic signed [ipi_pkg::KW-1:0]      data_y
);

  localparam ipi_pkg::krom_t KTAB = ipi_pkg::kernel_table();

  always_ff @(posedge clk) begin
    data_x <= KTAB[addr_x];
    data_y <= KTAB[addr_y];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ipi_mac.sv =====
`default_nettype none

module ipi_mac (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire ipi_pkg::mac_in_t                 tap,
  output logic signed [ipi_pkg::ACCW-1:0]       acc,
  output logic                                  busy
);

  logic                                v2;
  logic signed [ipi_pkg::WXYW-1:0]     wxy;
  logic [15:0]                         pix2;
  logic                                v3;
  logic signed [ipi_pkg::PW-1:0]       prod;

  assign busy = v2 | v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2  <= 1'b0;
      v3  <= 1'b0;
      acc <= '0;
    end else begin
      v2 <= tap.valid;
      v3 <= v2;
      if (tap.clear) begin
        acc <= '0;
      end else if (v3) begin
        acc <= acc + ipi_pkg::ACCW'(prod);
      end
    end
    wxy  <= ipi_pkg::WXYW'(tap.wx) * ipi_pkg::WXYW'(tap.wy);
    pix2 <= tap.pixel;
    prod <= ipi_pkg::PW'(wxy) * ipi_pkg::PW'($signed({1'b0, pix2}));
  end

endmodule

`default_nettype wire
